[sv/rpis_pkg.sv]
// shared types, codes and constants of the radial profile interpolation and splat unit
package rpis_pkg;

  // default table depth
  localparam int TABLE_DEPTH_DEF = 256;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 1'b1;
  localparam logic [CFG_DATA_W-1:0] INV_CELL_RESET = 31'd65536;

  // item kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_EVAL   = 2'd2;
  localparam logic [1:0] KIND_SPLAT  = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         entry_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] data_value;
    logic signed [31:0] adjoint_x;
    logic signed [31:0] adjoint_z;
    logic               active;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_z;
    logic signed [31:0] curv_xx;
    logic signed [31:0] curv_xz;
    logic signed [31:0] curv_zz;
  } out_item_t;

  // multiplier operand pairs
  typedef enum logic [4:0] {
    MS_NONE, MS_AXAX, MS_AZAZ, MS_RICS, MS_DIFFW, MS_DIFFICS, MS_SUX, MS_SUZ,
    MS_UXUX, MS_UXUZ, MS_UZUZ, MS_TQ, MS_VALW1, MS_VALW0, MS_ADJXUX, MS_ADJZUZ,
    MS_GRICS
  } mul_sel_t;

  // product writeback targets
  typedef enum logic [4:0] {
    WB_NONE, WB_SQX, WB_SQZ, WB_LOC, WB_SAMPLE, WB_RDOUT, WB_S, WB_SX, WB_SZ,
    WB_T1M, WB_TNEG, WB_CXX, WB_CXZ, WB_CZZ, WB_M0, WB_M1, WB_GX, WB_GZ, WB_GH
  } wb_t;

  typedef enum logic [1:0] {AS_IDX, AS_I0, AS_I1} addr_sel_t;
  typedef enum logic [1:0] {TW_NONE, TW_IN, TW_ADD} tab_wr_t;
  typedef enum logic [1:0] {AD_M0, AD_M1, AD_NGH, AD_GH} add_sel_t;
  typedef enum logic [1:0] {DV_UX, DV_UZ, DV_Q} div_sel_t;

  typedef struct packed {
    logic      load;
    logic      geo;
    addr_sel_t addr;
    tab_wr_t   twr;
    add_sel_t  add;
    logic      ld_v0;
    logic      ld_v1;
    mul_sel_t  mul;
    wb_t       wb;
    logic      sqrt_go;
    logic      div_go;
    div_sel_t  div;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       active;
    logic       r_zero;
    logic       clamp;
    logic       sqrt_done;
    logic       div_done;
  } dp_stat_t;

endpackage

[sv/rpis_sqrt.sv]
// iterative 64-bit integer square root, one result bit per cycle
module rpis_sqrt
  import rpis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  localparam int SQ_STEPS = 32;

  logic        running;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  // bit-pair restoring square root
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= radicand;
        res     <= '0;
        bitv    <= 64'h4000_0000_0000_0000;
      end else if (running) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(SQ_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/rpis_div.sv]
// iterative restoring divider, 48-bit dividend by 33-bit divisor, 31 quotient bits
module rpis_div
  import rpis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [47:0] num,
  input  logic [32:0] den,
  output logic [30:0] quo,
  output logic        ovf,
  output logic        done
);

  localparam int DV_STEPS = 31;

  logic        running;
  logic [4:0]  cnt;
  logic [32:0] rem;
  logic [30:0] nsh;
  logic [32:0] dreg;
  logic [33:0] trial;
  logic        ge;

  assign trial = {rem, nsh[30]};
  assign ge    = trial >= {1'b0, dreg};

  // one quotient bit per cycle; quotient overflow flagged up front
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= {16'd0, num[47:31]};
        nsh     <= num[30:0];
        dreg    <= den;
        quo     <= '0;
        ovf     <= {16'd0, num[47:31]} >= den;
      end else if (running) begin
        rem  <= ge ? 33'(trial - {1'b0, dreg}) : trial[32:0];
        quo  <= {quo[29:0], ge};
        nsh  <= {nsh[29:0], 1'b0};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(DV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/rpis_dp.sv]
// datapath: item and config registers, profile table, multiplier, root and divide units
module rpis_dp
  import rpis_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output out_item_t             result
);

  localparam int IW = $clog2(TABLE_DEPTH);

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fff_ffff;
    else if (v < -68'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  // config registers
  logic [CFG_DATA_W-1:0] ctr;
  logic [CFG_DATA_W-1:0] ics;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
      ics <= INV_CELL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER:   ctr <= cfg_data;
        CFG_INV_CELL: ics <= cfg_data;
        default: ;
      endcase
    end
  end

  // working registers
  in_item_t           itm;
  logic signed [32:0] dx, dz;
  logic [31:0]        ax, az;
  logic               sh;
  logic [63:0]        sum;
  logic [32:0]        r;
  logic signed [17:0] ux, uz;
  logic [IW-1:0]      i0, i1;
  logic [15:0]        w0;
  logic               clamp;
  logic signed [31:0] v0, v1, s, q, m0, m1, gr, gh;
  logic signed [32:0] t;
  logic signed [67:0] p, gacc;
  logic               dneg;
  out_item_t          res;

  // geometry from the latched item
  logic signed [32:0] dxc, dzc, mxc, mzc;
  logic               big;
  assign dxc = {itm.pos_x[31], itm.pos_x} - {2'b00, ctr};
  assign dzc = {itm.pos_z[31], itm.pos_z} - {2'b00, ctr};
  assign mxc = dxc[32] ? -dxc : dxc;
  assign mzc = dzc[32] ? -dzc : dzc;
  assign big = mxc[31] | mzc[31];

  // table location from r * inverse cell size
  logic [31:0] fl;
  logic        clampc;
  assign fl     = p[63:32];
  assign clampc = fl >= 32'(TABLE_DEPTH - 1);

  logic signed [32:0] diff;
  logic [16:0]        w1;
  assign diff = {v1[31], v1} - {v0[31], v0};
  assign w1   = 17'd65536 - {1'b0, w0};

  // multiplier operand select
  logic signed [33:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul)
      MS_AXAX:    begin ma = {2'b00, ax}; mb = {2'b00, ax}; end
      MS_AZAZ:    begin ma = {2'b00, az}; mb = {2'b00, az}; end
      MS_RICS:    begin ma = {1'b0, r}; mb = {3'b000, ics}; end
      MS_DIFFW:   begin ma = {diff[32], diff}; mb = {18'd0, w0}; end
      MS_DIFFICS: begin ma = {diff[32], diff}; mb = {3'b000, ics}; end
      MS_SUX:     begin ma = {{2{s[31]}}, s}; mb = {{16{ux[17]}}, ux}; end
      MS_SUZ:     begin ma = {{2{s[31]}}, s}; mb = {{16{uz[17]}}, uz}; end
      MS_UXUX:    begin ma = {{16{ux[17]}}, ux}; mb = {{16{ux[17]}}, ux}; end
      MS_UXUZ:    begin ma = {{16{ux[17]}}, ux}; mb = {{16{uz[17]}}, uz}; end
      MS_UZUZ:    begin ma = {{16{uz[17]}}, uz}; mb = {{16{uz[17]}}, uz}; end
      MS_TQ:      begin ma = {t[32], t}; mb = {{2{q[31]}}, q}; end
      MS_VALW1: begin
        ma = {{2{itm.data_value[31]}}, itm.data_value};
        mb = {17'd0, w1};
      end
      MS_VALW0: begin
        ma = {{2{itm.data_value[31]}}, itm.data_value};
        mb = {18'd0, w0};
      end
      MS_ADJXUX: begin
        ma = {{2{itm.adjoint_x[31]}}, itm.adjoint_x};
        mb = {{16{ux[17]}}, ux};
      end
      MS_ADJZUZ: begin
        ma = {{2{itm.adjoint_z[31]}}, itm.adjoint_z};
        mb = {{16{uz[17]}}, uz};
      end
      MS_GRICS:   begin ma = {{2{gr[31]}}, gr}; mb = {3'b000, ics}; end
      default: ;
    endcase
  end

  // floored and saturated Q16.16 product
  logic signed [31:0] mq;
  logic signed [67:0] gsum;
  assign mq   = sat32(p >>> 16);
  assign gsum = gacc + p;

  // profile table
  logic [31:0]   tab [TABLE_DEPTH];
  logic [31:0]   rdata;
  logic [IW-1:0] addr;
  logic [IW-1:0] idx_addr;
  logic          idx_ok;
  logic          we;
  logic [31:0]   wdata;
  logic signed [67:0] addend, addsum;

  assign idx_addr = IW'(itm.entry_index);
  assign idx_ok   = 32'(itm.entry_index) < 32'(TABLE_DEPTH);

  always_comb begin
    case (cmd.addr)
      AS_I0:   addr = i0;
      AS_I1:   addr = i1;
      default: addr = idx_addr;
    endcase
  end

  always_comb begin
    case (cmd.add)
      AD_M0:   addend = {{36{m0[31]}}, m0};
      AD_M1:   addend = {{36{m1[31]}}, m1};
      AD_NGH:  addend = -{{36{gh[31]}}, gh};
      default: addend = {{36{gh[31]}}, gh};
    endcase
  end

  assign addsum = {{36{rdata[31]}}, rdata} + addend;
  assign we     = (cmd.twr == TW_IN && idx_ok) || cmd.twr == TW_ADD;
  assign wdata  = (cmd.twr == TW_IN) ? itm.data_value : sat32(addsum);

  always_ff @(posedge clk) begin
    if (we) tab[addr] <= wdata;
    rdata <= tab[addr];
  end

  // root and divide units
  logic [31:0] root;
  logic        sqrt_done;
  logic [47:0] dnum;
  logic [30:0] quo;
  logic        ovf;
  logic        div_done;
  logic [32:0] mdx, mdz;
  logic [31:0] ms;

  assign mdx = dx[32] ? -dx : dx;
  assign mdz = dz[32] ? -dz : dz;
  assign ms  = s[31] ? 32'(-{s[31], s}) : s;

  always_comb begin
    case (cmd.div)
      DV_UX:   dnum = {mdx[31:0], 16'd0};
      DV_UZ:   dnum = {mdz[31:0], 16'd0};
      default: dnum = {ms, 16'd0};
    endcase
  end

  rpis_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.sqrt_go),
    .radicand (sum),
    .root     (root),
    .done     (sqrt_done)
  );

  rpis_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  (dnum),
    .den  (r),
    .quo  (quo),
    .ovf  (ovf),
    .done (div_done)
  );

  // quotient post-processing
  logic [16:0]        ulim;
  logic signed [17:0] uval;
  logic signed [31:0] qval;
  assign ulim = (quo > 31'd65536) ? 17'd65536 : quo[16:0];
  assign uval = dneg ? -{1'b0, ulim} : {1'b0, ulim};
  always_comb begin
    if (ovf) qval = dneg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else     qval = dneg ? -{1'b0, quo} : {1'b0, quo};
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p <= ma * mb;
    if (cmd.load) begin
      itm <= item;
      res <= '0;
      ux  <= '0;
      uz  <= '0;
    end
    if (cmd.geo) begin
      dx <= dxc;
      dz <= dzc;
      sh <= big;
      ax <= big ? {1'b0, mxc[31:1]} : mxc[31:0];
      az <= big ? {1'b0, mzc[31:1]} : mzc[31:0];
    end
    if (sqrt_done) r <= sh ? {root, 1'b0} : {1'b0, root};
    if (cmd.div_go) begin
      case (cmd.div)
        DV_UX:   dneg <= dx[32];
        DV_UZ:   dneg <= dz[32];
        default: dneg <= s[31];
      endcase
    end
    if (div_done) begin
      case (cmd.div)
        DV_UX:   ux <= uval;
        DV_UZ:   uz <= uval;
        default: q  <= qval;
      endcase
    end
    if (cmd.ld_v0) v0 <= rdata;
    if (cmd.ld_v1) v1 <= rdata;
    case (cmd.wb)
      WB_SQX: sum <= p[63:0];
      WB_SQZ: sum <= sum + p[63:0];
      WB_LOC: begin
        clamp <= clampc;
        i0    <= clampc ? IW'(TABLE_DEPTH - 1) : fl[IW-1:0];
        i1    <= clampc ? IW'(TABLE_DEPTH - 1) : fl[IW-1:0] + 1'b1;
        w0    <= clampc ? 16'd0 : p[31:16];
      end
      WB_SAMPLE: res.sample_value <= sat32($signed({{36{v0[31]}}, v0}) + (p >>> 16));
      WB_RDOUT:  res.sample_value <= idx_ok ? rdata : 32'd0;
      WB_S:      s <= mq;
      WB_SX:     res.slope_x <= mq;
      WB_SZ:     res.slope_z <= mq;
      WB_T1M:    t <= 33'sd65536 - {mq[31], mq};
      WB_TNEG:   t <= -{mq[31], mq};
      WB_CXX:    res.curv_xx <= mq;
      WB_CXZ:    res.curv_xz <= mq;
      WB_CZZ:    res.curv_zz <= mq;
      WB_M0:     m0 <= mq;
      WB_M1:     m1 <= mq;
      WB_GX:     gacc <= p;
      WB_GZ:     gr <= sat32(gsum >>> 16);
      WB_GH:     gh <= mq;
      default: ;
    endcase
  end

  // status back to the controller
  assign stat.kind      = itm.kind;
  assign stat.active    = itm.active;
  assign stat.r_zero    = (r == 33'd0);
  assign stat.clamp     = clamp;
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;

  assign result = res;

endmodule

[sv/rpis_ctrl.sv]
// controller: sequences the datapath through each item kind
module rpis_ctrl
  import rpis_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [5:0] {
    S_IDLE, S_DECODE, S_WRITE, S_RD_ADDR, S_RD_OUT, S_GEO, S_SQ_X, S_SQ_Z,
    S_SQ_SUM, S_SQRT_GO, S_SQRT_WAIT, S_LOC_MUL, S_LOC_WB, S_V0_ADDR,
    S_V1_ADDR, S_V1_LD, S_S_MUL, S_S_WB, S_SAMPLE_WB, S_UX_GO, S_UX_WAIT,
    S_UZ_GO, S_UZ_WAIT, S_Q_GO, S_Q_WAIT, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
    S_H7, S_H8, S_H9, S_H10, S_H11, S_H12, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
    S_P7, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8
  } state_t;

  state_t state, state_next;
  logic   done_next;

  assign busy = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_WRITE: state_next = S_WRITE;
          KIND_READ:  state_next = S_RD_ADDR;
          KIND_EVAL:  state_next = S_GEO;
          default:    state_next = stat.active ? S_GEO : S_IDLE;
        endcase
      end
      S_WRITE: begin
        cmd.addr   = AS_IDX;
        cmd.twr    = TW_IN;
        state_next = S_IDLE;
      end
      S_RD_ADDR: begin
        cmd.addr   = AS_IDX;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.wb     = WB_RDOUT;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      // radius
      S_GEO: begin
        cmd.geo    = 1'b1;
        state_next = S_SQ_X;
      end
      S_SQ_X: begin
        cmd.mul    = MS_AXAX;
        state_next = S_SQ_Z;
      end
      S_SQ_Z: begin
        cmd.wb     = WB_SQX;
        cmd.mul    = MS_AZAZ;
        state_next = S_SQ_SUM;
      end
      S_SQ_SUM: begin
        cmd.wb     = WB_SQZ;
        state_next = S_SQRT_GO;
      end
      S_SQRT_GO: begin
        cmd.sqrt_go = 1'b1;
        state_next  = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (stat.sqrt_done) state_next = S_LOC_MUL;
      end
      // table location and samples
      S_LOC_MUL: begin
        cmd.mul    = MS_RICS;
        state_next = S_LOC_WB;
      end
      S_LOC_WB: begin
        cmd.wb     = WB_LOC;
        state_next = S_V0_ADDR;
      end
      S_V0_ADDR: begin
        cmd.addr   = AS_I0;
        state_next = S_V1_ADDR;
      end
      S_V1_ADDR: begin
        cmd.addr   = AS_I1;
        cmd.ld_v0  = 1'b1;
        state_next = S_V1_LD;
      end
      S_V1_LD: begin
        cmd.ld_v1  = 1'b1;
        state_next = S_S_MUL;
      end
      S_S_MUL: begin
        cmd.mul    = MS_DIFFICS;
        state_next = S_S_WB;
      end
      S_S_WB: begin
        cmd.wb     = WB_S;
        cmd.mul    = MS_DIFFW;
        state_next = S_SAMPLE_WB;
      end
      S_SAMPLE_WB: begin
        cmd.wb = WB_SAMPLE;
        if (!stat.r_zero) begin
          state_next = S_UX_GO;
        end else if (stat.kind == KIND_EVAL) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_P1;
        end
      end
      // unit direction
      S_UX_GO: begin
        cmd.div_go = 1'b1;
        cmd.div    = DV_UX;
        state_next = S_UX_WAIT;
      end
      S_UX_WAIT: begin
        cmd.div = DV_UX;
        if (stat.div_done) state_next = S_UZ_GO;
      end
      S_UZ_GO: begin
        cmd.div_go = 1'b1;
        cmd.div    = DV_UZ;
        state_next = S_UZ_WAIT;
      end
      S_UZ_WAIT: begin
        cmd.div = DV_UZ;
        if (stat.div_done) state_next = (stat.kind == KIND_EVAL) ? S_Q_GO : S_P1;
      end
      S_Q_GO: begin
        cmd.div_go = 1'b1;
        cmd.div    = DV_Q;
        state_next = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        cmd.div = DV_Q;
        if (stat.div_done) state_next = S_H1;
      end
      // gradient and curvature terms
      S_H1:  begin cmd.mul = MS_SUX; state_next = S_H2; end
      S_H2:  begin cmd.wb = WB_SX; cmd.mul = MS_SUZ; state_next = S_H3; end
      S_H3:  begin cmd.wb = WB_SZ; cmd.mul = MS_UXUX; state_next = S_H4; end
      S_H4:  begin cmd.wb = WB_T1M; state_next = S_H5; end
      S_H5:  begin cmd.mul = MS_TQ; state_next = S_H6; end
      S_H6:  begin cmd.wb = WB_CXX; cmd.mul = MS_UXUZ; state_next = S_H7; end
      S_H7:  begin cmd.wb = WB_TNEG; state_next = S_H8; end
      S_H8:  begin cmd.mul = MS_TQ; state_next = S_H9; end
      S_H9:  begin cmd.wb = WB_CXZ; cmd.mul = MS_UZUZ; state_next = S_H10; end
      S_H10: begin cmd.wb = WB_T1M; state_next = S_H11; end
      S_H11: begin cmd.mul = MS_TQ; state_next = S_H12; end
      S_H12: begin
        cmd.wb     = WB_CZZ;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      // splat weights
      S_P1: begin cmd.mul = MS_VALW1; state_next = S_P2; end
      S_P2: begin cmd.wb = WB_M0; cmd.mul = MS_VALW0; state_next = S_P3; end
      S_P3: begin cmd.wb = WB_M1; cmd.mul = MS_ADJXUX; state_next = S_P4; end
      S_P4: begin cmd.wb = WB_GX; cmd.mul = MS_ADJZUZ; state_next = S_P5; end
      S_P5: begin cmd.wb = WB_GZ; state_next = S_P6; end
      S_P6: begin cmd.mul = MS_GRICS; state_next = S_P7; end
      S_P7: begin cmd.wb = WB_GH; cmd.addr = AS_I0; state_next = S_A2; end
      // table read-modify-write
      S_A2: begin
        cmd.addr   = AS_I0;
        cmd.twr    = TW_ADD;
        cmd.add    = AD_M0;
        state_next = S_A3;
      end
      S_A3: begin cmd.addr = AS_I1; state_next = S_A4; end
      S_A4: begin
        cmd.addr   = AS_I1;
        cmd.twr    = TW_ADD;
        cmd.add    = AD_M1;
        state_next = stat.clamp ? S_IDLE : S_A5;
      end
      S_A5: begin cmd.addr = AS_I0; state_next = S_A6; end
      S_A6: begin
        cmd.addr   = AS_I0;
        cmd.twr    = TW_ADD;
        cmd.add    = AD_NGH;
        state_next = S_A7;
      end
      S_A7: begin cmd.addr = AS_I1; state_next = S_A8; end
      S_A8: begin
        cmd.addr   = AS_I1;
        cmd.twr    = TW_ADD;
        cmd.add    = AD_GH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still busy");
  a_load_idle: assert property (@(posedge clk) disable iff (rst) cmd.load |-> !busy)
    else $error("item loaded while busy");
`endif

endmodule

[sv/radial_profile_interp_splat_unit.sv]
// top level of the radial profile interpolation and splat unit
//
// Usage: an item is taken at a rising edge where start is high and busy is low.
// Kinds: write entry, read entry, evaluate at a point, splat into the table.
// Read and evaluate give one result on result, marked by done for exactly one
// cycle; write and splat give none. The receiver cannot stall, so a result is
// taken in the cycle it is shown, and a new item may be started in that cycle.
// Configuration (center offset, inverse cell size) goes through cfg_we,
// cfg_index and cfg_data while busy is low; writes take effect at once.
// Write goes from decode to the table write; read goes through an address state
// and an output state. Evaluate with a nonzero radius runs the 32-step square
// root and three 31-step divisions (two unit-direction components and the
// curvature factor); at zero radius it stops after the root and the sample.
// Splat: root, two divisions when the radius is nonzero, then up to four table
// read-modify-writes through the single table port; an inactive splat does none.
// Items are processed one at a time. Reset initializes the sequencer and the
// configuration registers; table contents are undefined until written.
module radial_profile_interp_splat_unit
  import rpis_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item,
  output logic                  done,
  output out_item_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  rpis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // arithmetic and table
  rpis_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule
